// ===== rtl/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// types, constants and helpers shared by the matrix stack modules
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W      = $clog2(STACK_DEPTH);
    localparam int ADDR_W      = SLOT_W + 4;
    localparam int ACC_W       = 66;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         row_index;
        logic signed [31:0] elem_0;
        logic signed [31:0] elem_1;
        logic signed [31:0] elem_2;
        logic signed [31:0] elem_3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         out_row;
        logic signed [31:0] out_0;
        logic signed [31:0] out_1;
        logic signed [31:0] out_2;
        logic signed [31:0] out_3;
        logic [7:0]         stack_depth;
        logic               last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic              buf_wr;     // store input row into row buffer
        logic              mac_clr;    // first product of a dot product
        logic              mac_en;     // product issued this cycle
        logic              mac_last;   // last product, write sum back
        logic              copy_wr;    // write buffer element directly
        logic              rd;         // issue store read
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic [1:0]        ki;         // buffer element row
        logic [1:0]        kj;         // buffer element column
        logic              row_ld;     // latch read word into output row
        logic [1:0]        row_col;
    } t_dp_cmd;

    function automatic logic signed [31:0] sat_shift(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        begin
            s = a >>> 16;
            if (s > 66'sd2147483647)
                sat_shift = 32'sh7fffffff;
            else if (s < -66'sd2147483648)
                sat_shift = 32'sh80000000;
            else
                sat_shift = s[31:0];
        end
    endfunction

endpackage

// ===== rtl/tms_datapath.sv =====
// ----------------------------------------------------------------------------
// tms_datapath
// row buffer, matrix store memory, multiply-accumulate and output row
// ----------------------------------------------------------------------------
module tms_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tms_pkg::t_dp_cmd       i_cmd,
    input  tms_pkg::t_in_item      i_item,
    output logic [4*32-1:0]        o_row
);
    import tms_pkg::*;

    logic [31:0]             r_buf [16];
    logic [31:0]             r_mem [STACK_DEPTH*16];
    logic [31:0]             r_rd;
    logic signed [31:0]      r_bk;
    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [31:0]             r_row [4];
    logic [31:0]             w_b;
    logic                    r_v1, r_v2;
    logic                    r_c1, r_c2;
    logic                    r_l1, r_l2, r_l3;
    logic [ADDR_W-1:0]       r_wa1, r_wa2, r_wa3;

    assign w_b = r_buf[{i_cmd.ki, i_cmd.kj}];

    always_ff @(posedge i_clk) begin
        if (i_cmd.buf_wr) begin
            r_buf[{i_item.row_index, 2'd0}] <= i_item.elem_0;
            r_buf[{i_item.row_index, 2'd1}] <= i_item.elem_1;
            r_buf[{i_item.row_index, 2'd2}] <= i_item.elem_2;
            r_buf[{i_item.row_index, 2'd3}] <= i_item.elem_3;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_wr)
            r_mem[i_cmd.wr_addr] <= w_b;
        else if (r_l3)
            r_mem[r_wa3] <= sat_shift(r_acc);
        if (i_cmd.rd)
            r_rd <= r_mem[i_cmd.rd_addr];
    end

    // issue: read data and buffer element registered, then product, then sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0;
            r_l1 <= 1'b0; r_l2 <= 1'b0; r_l3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_en;
            r_v2 <= r_v1;
            r_l1 <= i_cmd.mac_en && i_cmd.mac_last;
            r_l2 <= r_l1;
            r_l3 <= r_l2;
        end
        r_c1   <= i_cmd.mac_clr;
        r_c2   <= r_c1;
        r_wa1  <= i_cmd.wr_addr;
        r_wa2  <= r_wa1;
        r_wa3  <= r_wa2;
        r_bk   <= w_b;
        r_prod <= r_bk * $signed(r_rd);
    end

    always_ff @(posedge i_clk) begin
        if (r_v2)
            r_acc <= (r_c2 ? '0 : r_acc) + ACC_W'(r_prod);
        if (i_cmd.row_ld)
            r_row[i_cmd.row_col] <= r_rd;
    end

    assign o_row = {r_row[3], r_row[2], r_row[1], r_row[0]};

endmodule

// ===== rtl/tms_ctrl.sv =====
// ----------------------------------------------------------------------------
// tms_ctrl
// command decode, depth count and sequencing of store accesses
// ----------------------------------------------------------------------------
module tms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tms_pkg::t_in_item i_item,
    output tms_pkg::t_dp_cmd  o_cmd,
    input  logic [4*32-1:0]   i_row,
    output logic              o_valid,
    input  logic              i_ready,
    output tms_pkg::t_out_item o_item
);
    import tms_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COPY = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RDRW = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [6:0] MUL_LAST_ISSUE = 7'd63;
    localparam logic [6:0] MUL_DONE       = 7'd66;

    logic [2:0]         r_st, n_st;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [6:0]         r_cnt, n_cnt;      // sequence counter
    logic [1:0]         r_orow, n_orow;
    logic [SLOT_W-1:0]  r_dst, n_dst, r_src, n_src;
    logic               r_ov, n_ov;
    t_out_item          r_out, n_out;
    logic               w_acc;
    logic [SLOT_W-1:0]  w_top;

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign w_top   = SLOT_W'(r_depth - DEPTH_W'(1));

    always_comb begin
        n_st = r_st; n_depth = r_depth; n_cnt = r_cnt; n_orow = r_orow;
        n_dst = r_dst; n_src = r_src; n_ov = r_ov; n_out = r_out;
        o_cmd = '0;
        if (r_ov && i_ready)
            n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    n_out = '0;
                    n_out.last = 1'b1;
                    case (i_item.command)
                        CMD_PUSH: begin
                            o_cmd.buf_wr = 1'b1;
                            if (i_item.row_index == 2'd3) begin
                                if (r_depth == DEPTH_W'(STACK_DEPTH)) begin
                                    n_out.status = ST_FULL;
                                    n_out.stack_depth = 8'(r_depth);
                                    n_ov = 1'b1;
                                end else begin
                                    n_dst = SLOT_W'(r_depth);
                                    n_src = w_top;
                                    n_cnt = '0;
                                    n_st = (r_depth == '0) ? S_COPY : S_MUL;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (r_depth == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_depth = r_depth - DEPTH_W'(1);
                            end
                            n_out.stack_depth = 8'(n_depth);
                            n_ov = 1'b1;
                        end
                        CMD_RESET: begin
                            n_depth = '0;
                            n_out.stack_depth = 8'd0;
                            n_ov = 1'b1;
                        end
                        default: begin
                            if (r_depth == '0) begin
                                n_out.status = ST_EMPTY;
                                n_out.stack_depth = 8'd0;
                                n_ov = 1'b1;
                            end else begin
                                n_src = w_top;
                                n_orow = 2'd0;
                                n_cnt = '0;
                                n_st = S_RDRW;
                            end
                        end
                    endcase
                end
            end
            S_COPY: begin
                o_cmd.copy_wr = 1'b1;
                o_cmd.ki = r_cnt[3:2];
                o_cmd.kj = r_cnt[1:0];
                o_cmd.wr_addr = {r_dst, r_cnt[3:0]};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd15) begin
                    n_depth = r_depth + DEPTH_W'(1);
                    n_src = r_dst; n_orow = 2'd0; n_cnt = '0;
                    n_st = S_RDRW;
                end
            end
            S_MUL: begin
                // cnt[5:4] row i, cnt[3:2] column j, cnt[1:0] term k
                if (r_cnt <= MUL_LAST_ISSUE) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_addr = {r_src, r_cnt[1:0], r_cnt[3:2]};
                    o_cmd.ki = r_cnt[5:4];
                    o_cmd.kj = r_cnt[1:0];
                    o_cmd.mac_en = 1'b1;
                    o_cmd.mac_clr = (r_cnt[1:0] == 2'd0);
                    o_cmd.mac_last = (r_cnt[1:0] == 2'd3);
                    o_cmd.wr_addr = {r_dst, r_cnt[5:2]};
                end
                n_cnt = r_cnt + 7'd1;
                // wait for the last sum to reach the store
                if (r_cnt == MUL_DONE) begin
                    n_depth = r_depth + DEPTH_W'(1);
                    n_src = r_dst; n_orow = 2'd0; n_cnt = '0;
                    n_st = S_RDRW;
                end
            end
            S_RDRW: begin
                o_cmd.rd = (r_cnt[2:0] < 3'd4);
                o_cmd.rd_addr = {r_src, r_orow, r_cnt[1:0]};
                o_cmd.row_ld = (r_cnt[2:0] >= 3'd1) && (r_cnt[2:0] <= 3'd4);
                o_cmd.row_col = 2'(r_cnt[2:0] - 3'd1);
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[2:0] == 3'd5) begin
                    n_out.status = ST_OK;
                    n_out.out_row = r_orow;
                    {n_out.out_3, n_out.out_2, n_out.out_1, n_out.out_0} = i_row;
                    n_out.stack_depth = 8'(r_depth);
                    n_out.last = (r_orow == 2'd3);
                    n_ov = 1'b1;
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                if (r_ov && i_ready) begin
                    if (r_orow == 2'd3) begin
                        n_st = S_IDLE;
                    end else begin
                        n_orow = r_orow + 2'd1;
                        n_cnt = '0;
                        n_st = S_RDRW;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_depth <= '0; r_ov <= 1'b0;
            r_cnt <= '0; r_orow <= '0;
        end else begin
            r_st <= n_st; r_depth <= n_depth; r_ov <= n_ov;
            r_cnt <= n_cnt; r_orow <= n_orow;
        end
        r_dst <= n_dst; r_src <= n_src; r_out <= n_out;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH)) else $error("depth overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready with pending result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_item)) else $error("result changed");

endmodule

// ===== rtl/transform_matrix_stack_core.sv =====
// ----------------------------------------------------------------------------
// transform_matrix_stack_core
// bounded stack of 4x4 s15.16 matrices with push-multiply
// ----------------------------------------------------------------------------
// A push row is taken without giving a result. A completing push on an empty
// stack copies the 16 buffer elements into the new top; otherwise the new top
// is formed with one product per cycle through the single store read port,
// 64 products followed by a pipeline drain. The four rows of the new top then
// follow, each gathered by store reads and then held on the output until
// taken; read top uses the same readout. Pop, reset and the full and empty
// cases give their one result the cycle after the transfer, and no input is
// taken while a result is waiting or being formed, so output stalls hold the
// whole block.
module transform_matrix_stack_core
    import tms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);
    t_dp_cmd        w_cmd;
    logic [127:0]   w_row;

    tms_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(i_data),
        .o_cmd(w_cmd), .i_row(w_row), .o_valid, .i_ready, .o_item(o_data)
    );

    tms_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_item(i_data), .o_row(w_row)
    );

endmodule
